[rtl/zph_pkg.sv]
package zph_pkg;

   // Board geometry is fixed: rows and columns are 3-bit fields
   localparam int BOARD_SIDE = 8;
   localparam int SQUARE_BITS = 6;

   // Key generator
   localparam logic [63:0] SEED_VALUE = 64'd1070372;
   localparam int SHIFT_A = 13;
   localparam int SHIFT_B = 7;
   localparam int SHIFT_C = 17;

   // Work queue between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      ACT_PIECE  = 2'd0,
      ACT_SIDE   = 2'd1,
      ACT_CASTLE = 2'd2,
      ACT_EP     = 2'd3
   } action_type;

   // Per-word control carried from front to back
   typedef struct packed {
      logic use_key;
      logic last;
   } feat_flags_type;

   // One xorshift64 step
   function automatic logic [63:0] xorshift_step(input logic [63:0] x);
      logic [63:0] a;
      logic [63:0] b;
      a = x ^ (x << SHIFT_A);
      b = a ^ (a >> SHIFT_B);
      return b ^ (b << SHIFT_C);
   endfunction

endpackage

[rtl/zph_ram.sv]
module zph_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 909
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/zph_fill.sv]
module zph_fill #(
   parameter int KEY_TOTAL = 909
) (
   input  logic                         clock,
   input  logic                         reset,
   output logic                         wr_en,
   output logic [$clog2(KEY_TOTAL)-1:0] wr_addr,
   output logic [63:0]                  wr_data,
   output logic                         fill_done
);

   localparam int AW = $clog2(KEY_TOTAL);
   localparam int CW = $clog2(KEY_TOTAL + 1);

   logic [63:0]   gen_ff, gen_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [63:0]   gen_next;
   logic          busy;

   // One generator step and one key write per cycle until the table is full
   assign busy     = (idx_ff != CW'(KEY_TOTAL));
   assign gen_next = zph_pkg::xorshift_step(gen_ff);

   always_comb begin
      gen_in = gen_ff;
      idx_in = idx_ff;
      if (busy) begin
         gen_in = gen_next;
         idx_in = idx_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= zph_pkg::SEED_VALUE;
         idx_ff <= '0;
      end else begin
         gen_ff <= gen_in;
         idx_ff <= idx_in;
      end
   end

   assign wr_en     = busy;
   assign wr_addr   = idx_ff[AW-1:0];
   assign wr_data   = gen_next;
   assign fill_done = !busy;

endmodule

[rtl/zph_front.sv]
module zph_front #(
   parameter int PIECE_KINDS = 7
) (
   input  logic                       fill_done,
   input  logic                       queue_full,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [1:0]                 action,
   input  logic                       occupied,
   input  logic                       color,
   input  logic [2:0]                 piece_type,
   input  logic [2:0]                 row,
   input  logic [2:0]                 column,
   input  logic                       castle_side,
   input  logic                       last,
   output logic                       push,
   output zph_pkg::feat_flags_type    push_flags,
   output logic [$clog2(2 * PIECE_KINDS * zph_pkg::BOARD_SIDE * zph_pkg::BOARD_SIDE
                        + 5 + zph_pkg::BOARD_SIDE)-1:0] push_slot
);

   localparam int PIECE_KEYS  = 2 * PIECE_KINDS * zph_pkg::BOARD_SIDE * zph_pkg::BOARD_SIDE;
   localparam int SIDE_SLOT   = PIECE_KEYS;
   localparam int CASTLE_BASE = PIECE_KEYS + 1;
   localparam int EP_BASE     = PIECE_KEYS + 5;
   localparam int KEY_TOTAL   = PIECE_KEYS + 5 + zph_pkg::BOARD_SIDE;
   localparam int AW          = $clog2(KEY_TOTAL);
   localparam int PW          = AW - zph_pkg::SQUARE_BITS;

   logic [PW-1:0] plane;
   logic          kind_ok;

   // Accept words once the key table is loaded and the queue has room
   assign in_ready = fill_done && !queue_full;
   assign push     = in_valid && in_ready;

   // Piece key plane: color * PIECE_KINDS + piece type
   assign plane   = (color ? PW'(PIECE_KINDS) : '0) + PW'(piece_type);
   assign kind_ok = ({1'b0, piece_type} < 4'(PIECE_KINDS));

   // Classify the feature into a key slot
   always_comb begin
      push_flags.last    = last;
      push_flags.use_key = 1'b0;
      push_slot          = '0;
      unique case (zph_pkg::action_type'(action))
         zph_pkg::ACT_PIECE: begin
            push_flags.use_key = occupied && kind_ok;
            push_slot          = {plane, row, column};
         end
         zph_pkg::ACT_SIDE: begin
            push_flags.use_key = 1'b1;
            push_slot          = AW'(SIDE_SLOT);
         end
         zph_pkg::ACT_CASTLE: begin
            push_flags.use_key = 1'b1;
            push_slot          = AW'(CASTLE_BASE) + AW'({color, castle_side});
         end
         zph_pkg::ACT_EP: begin
            push_flags.use_key = 1'b1;
            push_slot          = AW'(EP_BASE) + AW'(column);
         end
         default: begin
            push_flags.use_key = 1'b0;
         end
      endcase
   end

endmodule

[rtl/zph_queue.sv]
module zph_queue #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in;
   logic [PW-1:0]    rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and occupancy update, wrapping at DEPTH
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + PW'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

endmodule

[rtl/zph_back.sv]
module zph_back #(
   parameter int AW = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  zph_pkg::feat_flags_type head_flags,
   input  logic [AW-1:0]           head_slot,
   output logic                    pop,
   output logic                    rd_en,
   output logic [AW-1:0]           rd_addr,
   input  logic [63:0]             rd_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [63:0]             rsp_hash
);

   zph_pkg::feat_flags_type s2_flags_ff, s2_flags_in;
   logic                    s2_valid_ff, s2_valid_in;
   logic [63:0]             acc_ff, acc_in;
   logic                    out_valid_ff, out_valid_in;
   logic [63:0]             out_hash_ff, out_hash_in;
   logic [63:0]             key;
   logic [63:0]             sum;
   logic                    out_free;
   logic                    s2_adv;
   logic                    issue;

   // Stage 2 retires unless it must emit and the output register is held
   assign out_free = !out_valid_ff || rsp_ready;
   assign s2_adv   = s2_valid_ff && (!s2_flags_ff.last || out_free);
   assign issue    = head_valid && (!s2_valid_ff || s2_adv);
   assign pop      = issue;
   assign rd_en    = issue;
   assign rd_addr  = head_slot;

   assign key = s2_flags_ff.use_key ? rd_data : '0;
   assign sum = acc_ff ^ key;

   always_comb begin
      s2_valid_in  = s2_valid_ff;
      s2_flags_in  = s2_flags_ff;
      acc_in       = acc_ff;
      out_valid_in = out_valid_ff;
      out_hash_in  = out_hash_ff;
      // read issue moves the queue head into stage 2
      if (issue) begin
         s2_valid_in = 1'b1;
         s2_flags_in = head_flags;
      end else if (s2_adv) begin
         s2_valid_in = 1'b0;
      end
      // output register drains on handshake
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      // fold the key in; on last emit and clear
      if (s2_adv) begin
         if (s2_flags_ff.last) begin
            acc_in       = '0;
            out_valid_in = 1'b1;
            out_hash_in  = sum;
         end else begin
            acc_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_flags_ff <= s2_flags_in;
      out_hash_ff <= out_hash_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_hash  = out_hash_ff;

endmodule

[rtl/zobrist_position_hash_unit.sv]
// Zobrist position hash unit.
// After reset the unit loads its key table with an xorshift64 sequence, one
// key per cycle through the single write port of the key RAM, for a table of
// 2*PIECE_KINDS*64 + 13 keys (909 at PIECE_KINDS = 7). req_tready stays low
// until the load completes.
// req channel: one word per position feature. tuser carries the action
// (piece on square, black to move, castling right, en passant column), tdata
// the feature fields, tlast marks the final feature of a position.
// rsp channel: one 64-bit hash word per position, sent after the tlast word
// has been folded in; the accumulator then restarts from zero.
// Throughput: one feature word per cycle while no hash waits in the output
// register, bounded by the one key RAM read per word. A tlast word passes
// through the queue, the RAM read and the output register to reach rsp.
// A 4-entry queue separates the decoding front from the RAM/accumulate back.
// When rsp_tready is low the hash waits in the output register; features of
// the next position keep flowing until the queue fills, then req_tready
// drops.
module zobrist_position_hash_unit #(
   parameter int PIECE_KINDS = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] occupied, [1] color, [4:2] piece_type, [7:5] row, [10:8] column,
   // [11] castle_side, [15:12] zero
   input  logic [15:0] req_tdata,
   // [1:0] action
   input  logic [1:0]  req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [63:0] hash
   output logic [63:0] rsp_tdata
);

   localparam int KEY_TOTAL =
      2 * PIECE_KINDS * zph_pkg::BOARD_SIDE * zph_pkg::BOARD_SIDE + 5 + zph_pkg::BOARD_SIDE;
   localparam int AW = $clog2(KEY_TOTAL);
   localparam int QW = AW + $bits(zph_pkg::feat_flags_type);

   logic                    fill_wr_en;
   logic [AW-1:0]           fill_wr_addr;
   logic [63:0]             fill_wr_data;
   logic                    fill_done;
   logic                    q_full;
   logic                    push;
   zph_pkg::feat_flags_type push_flags;
   logic [AW-1:0]           push_slot;
   logic                    pop;
   logic                    head_valid;
   logic [QW-1:0]           head_data;
   zph_pkg::feat_flags_type head_flags;
   logic [AW-1:0]           head_slot;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic [63:0]             rd_data;

   // Key table load after reset
   zph_fill #(
      .KEY_TOTAL(KEY_TOTAL)
   ) u_fill (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (fill_wr_en),
      .wr_addr  (fill_wr_addr),
      .wr_data  (fill_wr_data),
      .fill_done(fill_done)
   );

   // Key table
   zph_ram #(
      .WIDTH(64),
      .DEPTH(KEY_TOTAL)
   ) u_keys (
      .clock  (clock),
      .wr_en  (fill_wr_en),
      .wr_addr(fill_wr_addr),
      .wr_data(fill_wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Feature decode
   zph_front #(
      .PIECE_KINDS(PIECE_KINDS)
   ) u_front (
      .fill_done  (fill_done),
      .queue_full (q_full),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .action     (req_tuser),
      .occupied   (req_tdata[0]),
      .color      (req_tdata[1]),
      .piece_type (req_tdata[4:2]),
      .row        (req_tdata[7:5]),
      .column     (req_tdata[10:8]),
      .castle_side(req_tdata[11]),
      .last       (req_tlast),
      .push       (push),
      .push_flags (push_flags),
      .push_slot  (push_slot)
   );

   // Front-to-back queue
   zph_queue #(
      .WIDTH(QW),
      .DEPTH(zph_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_flags, push_slot}),
      .full      (q_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_data (head_data)
   );

   assign head_flags = zph_pkg::feat_flags_type'(head_data[QW-1:AW]);
   assign head_slot  = head_data[AW-1:0];

   // Key read, accumulate and emit
   zph_back #(
      .AW(AW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_flags(head_flags),
      .head_slot (head_slot),
      .pop       (pop),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_hash  (rsp_tdata)
   );

endmodule

[tb/sv/zobrist_hash_checker.sv]
module zobrist_hash_checker #(
   parameter int PIECE_KINDS = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // [0] occupied, [1] color, [4:2] piece_type, [7:5] row, [10:8] column,
   // [11] castle_side, [15:12] zero
   input  logic [15:0] req_tdata,
   // [1:0] action
   input  logic [1:0]  req_tuser,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [63:0] hash
   input  logic [63:0] rsp_tdata,
   output int          mismatches,
   output int          hashes_pending
);

   // Key table layout: pieces, side to move, castling, en passant
   localparam int PIECE_KEYS  = 2 * PIECE_KINDS * 64;
   localparam int SIDE_KEY    = PIECE_KEYS;
   localparam int CASTLE_KEYS = PIECE_KEYS + 1;
   localparam int EP_KEYS     = PIECE_KEYS + 5;
   localparam int KEY_COUNT   = EP_KEYS + 8;
   localparam logic [63:0] GEN_SEED = 64'd1070372;

   logic [63:0] zobrist_keys [KEY_COUNT];
   logic [63:0] running_hash;
   logic [63:0] hash_queue [$];
   int          error_total = 0;

   // Same xorshift64 sequence the unit loads after reset
   initial begin : build_keys
      logic [63:0] x;
      x = GEN_SEED;
      for (int i = 0; i < KEY_COUNT; i++) begin
         x ^= x << 13;
         x ^= x >> 7;
         x ^= x << 17;
         zobrist_keys[i] = x;
      end
   end

   // Key folded in by one feature word, zero when the word contributes nothing
   function automatic logic [63:0] feature_key(input zph_pkg::action_type act,
                                               input logic [15:0] f);
      logic       occupied;
      logic       color;
      logic       castle_side;
      logic [2:0] piece;
      logic [2:0] row;
      logic [2:0] column;
      int         slot;
      occupied    = f[0];
      color       = f[1];
      piece       = f[4:2];
      row         = f[7:5];
      column      = f[10:8];
      castle_side = f[11];
      slot        = -1;
      case (act)
         zph_pkg::ACT_PIECE: begin
            if (occupied && int'(piece) < PIECE_KINDS)
               slot = ((int'(color) * PIECE_KINDS + int'(piece)) * 8 + int'(row)) * 8
                      + int'(column);
         end
         zph_pkg::ACT_SIDE:   slot = SIDE_KEY;
         zph_pkg::ACT_CASTLE: slot = CASTLE_KEYS + int'(color) * 2 + int'(castle_side);
         default:             slot = EP_KEYS + int'(column);
      endcase
      return (slot >= 0 && slot < KEY_COUNT) ? zobrist_keys[slot] : 64'd0;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] hash check error: %s", $realtime, msg);
      error_total++;
   endtask

   // Compare result words, then fold in accepted feature words
   always @(posedge clock) begin : track
      logic [63:0] wanted;
      if (reset) begin
         running_hash = '0;
         hash_queue.delete();
      end else begin
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            if (hash_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected hash word %h", rsp_tdata));
            end else begin
               wanted = hash_queue.pop_front();
               if (rsp_tdata !== wanted)
                  report_mismatch($sformatf("hash %h, predicted %h", rsp_tdata, wanted));
            end
         end
         if (req_tvalid === 1'b1 && req_tready === 1'b1) begin
            running_hash ^= feature_key(zph_pkg::action_type'(req_tuser), req_tdata);
            if (req_tlast) begin
               hash_queue.push_back(running_hash);
               running_hash = '0;
            end
         end
      end
      mismatches     <= error_total;
      hashes_pending <= hash_queue.size();
   end

endmodule

[tb/sv/tb_zobrist_position_hash_unit.sv]
module tb_zobrist_position_hash_unit;

   localparam int RUN_LIMIT    = 200000;
   localparam int RANDOM_WORDS = 1600;
   localparam int HOLD_CYCLES  = 300;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // [0] occupied, [1] color, [4:2] piece_type, [7:5] row, [10:8] column,
   // [11] castle_side, [15:12] zero
   logic [15:0] req_tdata;
   // [1:0] action
   logic [1:0]  req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // [63:0] hash
   logic [63:0] rsp_tdata;

   int   mismatches;
   int   hashes_pending;
   int   cycle_count = 0;
   int   burst_left  = 0;
   int   words_sent  = 0;
   logic hold_request = 1'b0;

   zobrist_position_hash_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   zobrist_hash_checker hash_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatches     (mismatches),
      .hashes_pending (hashes_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Offer one feature word; bursts with random gaps in between
   task automatic send_word(input zph_pkg::action_type act, input logic occupied,
                            input logic color, input logic [2:0] piece,
                            input logic [2:0] row, input logic [2:0] column,
                            input logic castle_side, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            req_tdata  <= 16'($urandom);
            req_tuser  <= 2'($urandom);
            req_tlast  <= 1'($urandom);
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                 : $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {4'b0000, castle_side, column, row, piece, color, occupied};
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      words_sent++;
   endtask

   // One position: mostly well-formed features, some noise words
   task automatic send_position();
      int   n;
      int   sel;
      logic last;
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
         last = (i == n - 1);
         sel  = $urandom_range(0, 99);
         if (sel < 10)
            send_word(zph_pkg::action_type'(2'($urandom_range(0, 3))), 1'($urandom),
                      1'($urandom), 3'($urandom), 3'($urandom), 3'($urandom),
                      1'($urandom), 1'($urandom));
         else if (sel < 65)
            send_word(zph_pkg::ACT_PIECE, 1'b1, 1'($urandom),
                      ($urandom_range(0, 19) == 0) ? 3'd7 : 3'($urandom_range(0, 6)),
                      3'($urandom), 3'($urandom), 1'($urandom), last);
         else if (sel < 72)
            send_word(zph_pkg::ACT_PIECE, 1'b0, 1'($urandom), 3'($urandom),
                      3'($urandom), 3'($urandom), 1'($urandom), last);
         else if (sel < 80)
            send_word(zph_pkg::ACT_SIDE, 1'($urandom), 1'($urandom), 3'($urandom),
                      3'($urandom), 3'($urandom), 1'($urandom), last);
         else if (sel < 92)
            send_word(zph_pkg::ACT_CASTLE, 1'($urandom), 1'($urandom), 3'($urandom),
                      3'($urandom), 3'($urandom), 1'($urandom), last);
         else
            send_word(zph_pkg::ACT_EP, 1'($urandom), 1'($urandom), 3'($urandom),
                      3'($urandom), 3'($urandom), 1'($urandom), last);
      end
   endtask

   // Receiver: changing ready patterns, plus one long hold-off
   initial begin : receiver
      int   mode;
      int   phase;
      logic hold_done;
      mode       = 0;
      phase      = 0;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (phase == 0) begin
            mode  = $urandom_range(0, 3);
            phase = $urandom_range(16, 96);
         end
         phase--;
         case (mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 3) != 0);
            2:       rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= (phase % 5 != 0);
         endcase
         @(posedge clock);
      end
   end

   // Stimulus and verdict
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      req_tlast  = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Board corners, lowest and highest piece keys
      send_word(zph_pkg::ACT_PIECE, 1'b1, 1'b0, 3'd0, 3'd0, 3'd0, 1'b0, 1'b1);
      send_word(zph_pkg::ACT_PIECE, 1'b1, 1'b1, 3'd6, 3'd7, 3'd7, 1'b1, 1'b1);
      // Empty square and unknown piece type give a zero hash
      send_word(zph_pkg::ACT_PIECE, 1'b0, 1'b1, 3'd3, 3'd4, 3'd5, 1'b0, 1'b1);
      send_word(zph_pkg::ACT_PIECE, 1'b1, 1'b1, 3'd7, 3'd7, 3'd7, 1'b1, 1'b1);
      // Side to move, with unused fields all ones
      send_word(zph_pkg::ACT_SIDE, 1'b1, 1'b1, 3'd7, 3'd7, 3'd7, 1'b1, 1'b1);
      // All four castling rights, one position
      send_word(zph_pkg::ACT_CASTLE, 1'b0, 1'b0, 3'd0, 3'd0, 3'd0, 1'b0, 1'b0);
      send_word(zph_pkg::ACT_CASTLE, 1'b1, 1'b0, 3'd7, 3'd7, 3'd7, 1'b1, 1'b0);
      send_word(zph_pkg::ACT_CASTLE, 1'b0, 1'b1, 3'd0, 3'd0, 3'd0, 1'b0, 1'b0);
      send_word(zph_pkg::ACT_CASTLE, 1'b1, 1'b1, 3'd7, 3'd7, 3'd7, 1'b1, 1'b1);
      // En passant on both edge files, other fields ignored
      send_word(zph_pkg::ACT_EP, 1'b1, 1'b1, 3'd7, 3'd7, 3'd0, 1'b1, 1'b1);
      send_word(zph_pkg::ACT_EP, 1'b0, 1'b0, 3'd0, 3'd0, 3'd7, 1'b0, 1'b1);
      // Same piece twice cancels
      send_word(zph_pkg::ACT_PIECE, 1'b1, 1'b0, 3'd2, 3'd3, 3'd4, 1'b0, 1'b0);
      send_word(zph_pkg::ACT_PIECE, 1'b1, 1'b0, 3'd2, 3'd3, 3'd4, 1'b1, 1'b1);
      // Mixed position
      send_word(zph_pkg::ACT_PIECE, 1'b1, 1'b0, 3'd5, 3'd0, 3'd4, 1'b0, 1'b0);
      send_word(zph_pkg::ACT_PIECE, 1'b1, 1'b1, 3'd5, 3'd7, 3'd4, 1'b0, 1'b0);
      send_word(zph_pkg::ACT_SIDE, 1'b0, 1'b0, 3'd0, 3'd0, 3'd0, 1'b0, 1'b0);
      send_word(zph_pkg::ACT_EP, 1'b0, 1'b0, 3'd0, 3'd0, 3'd3, 1'b0, 1'b1);

      // Random positions; long receiver hold-off early on
      hold_request <= 1'b1;
      words_sent = 0;
      while (words_sent < RANDOM_WORDS)
         send_position();

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (hashes_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && hashes_pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[zobrist_position_hash_unit.f]
rtl/zph_pkg.sv
rtl/zph_ram.sv
rtl/zph_fill.sv
rtl/zph_front.sv
rtl/zph_queue.sv
rtl/zph_back.sv
rtl/zobrist_position_hash_unit.sv
tb/sv/zobrist_hash_checker.sv
tb/sv/tb_zobrist_position_hash_unit.sv
